### rtl/set_assoc_cache_lru_sim_top_macros.svh
// Assertion macros shared by the cache simulator RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SET_ASSOC_CACHE_LRU_SIM_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_TOP_MACROS_SVH
`ifndef SYNTH
`define SAC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cache simulator assertion failed");
`define SAC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cache simulator assertion failed");
`else
`define SAC_ASSERT(lbl, clk, rst_n, prop)
`define SAC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/sac_pkg.sv
// Package of the cache simulator: sizes, register indexes, FSM states, shared types and a saturating increment.
// Used by sac_ctrl, sac_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
package sac_pkg;

  localparam int unsigned MAX_SETS   = 64;
  localparam int unsigned MAX_WAYS   = 4;
  localparam int unsigned SET_W      = $clog2(MAX_SETS);
  localparam int unsigned WAY_W      = $clog2(MAX_WAYS);
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned TAG_W      = 64;
  localparam int unsigned STAMP_W    = 64;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned SETB_W     = 3;
  localparam int unsigned OFFB_W     = 6;
  localparam int unsigned WAYS_W     = 3;
  localparam int unsigned SHIFT_W    = 7;
  localparam int unsigned LINE_W     = TAG_W + STAMP_W;
  localparam int unsigned ROW_W      = MAX_WAYS * LINE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

### rtl/sac_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds one row per set of the cache; no package dependencies.
`timescale 1ns / 1ps
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sac_ctrl.sv
// Controller of the cache simulator: request FSM and result valid flag.
// Depends on sac_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_sim_top_macros.svh"
module sac_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sac_pkg::dp_cmd_t cmd_o
);

  sac_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sac_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sac_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sac_pkg::ST_LOOKUP;
        end
      end
      sac_pkg::ST_LOOKUP: begin
        // The row read is held in the RAM output until the result slot is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = sac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sac_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.commit | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != sac_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  `SAC_ASSERT(a_accept_to_lookup, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> (state_q == sac_pkg::ST_LOOKUP))
  `SAC_ASSERT(a_commit_result, clk_i, rst_ni, cmd_o.commit |=> (out_valid_q && (state_q == sac_pkg::ST_IDLE)))
  `SAC_ASSERT(a_rose_from_commit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_o.commit))
  `SAC_ASSERT_ALWAYS(a_cmd_exclusive, clk_i, !(cmd_o.capture && cmd_o.commit))

endmodule

### rtl/sac_dp.sv
// Datapath of the cache simulator: config registers, address split, set row RAM,
// valid bits, hit and LRU logic, access stamp and saturating totals.
// Depends on sac_pkg and sac_ram.
`timescale 1ns / 1ps
module sac_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sac_pkg::dp_cmd_t                   cmd_i,
  input  logic                               cfg_we_i,
  input  logic [sac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [sac_pkg::ADDR_W-1:0]         address_i,
  output logic                               was_hit_o,
  output logic                               was_miss_o,
  output logic                               was_eviction_o,
  output logic [sac_pkg::CNT_W-1:0]          hit_total_o,
  output logic [sac_pkg::CNT_W-1:0]          miss_total_o,
  output logic [sac_pkg::CNT_W-1:0]          eviction_total_o
);

  localparam int unsigned NW = sac_pkg::MAX_WAYS;

  // Configuration registers.
  logic [sac_pkg::SETB_W-1:0] set_bits_q;
  logic [sac_pkg::OFFB_W-1:0] offset_bits_q;
  logic [sac_pkg::WAYS_W-1:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= '0;
      offset_bits_q <= '0;
      ways_q        <= sac_pkg::WAYS_W'(1);
    end else if (cfg_we_i) begin
      case (sac_pkg::cfg_idx_e'(cfg_index_i))
        sac_pkg::CFG_SET_BITS:    set_bits_q    <= cfg_data_i[sac_pkg::SETB_W-1:0];
        sac_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i[sac_pkg::OFFB_W-1:0];
        sac_pkg::CFG_WAYS_IN_USE: ways_q        <= cfg_data_i[sac_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split, done as the request is accepted.
  logic [sac_pkg::SHIFT_W-1:0] shift_sum;
  logic [sac_pkg::TAG_W-1:0]   tag_d, tag_q;
  logic [sac_pkg::ADDR_W-1:0]  addr_sh;
  logic [sac_pkg::SET_W-1:0]   set_mask, set_d, set_q;

  always_comb begin
    shift_sum = sac_pkg::SHIFT_W'(set_bits_q) + sac_pkg::SHIFT_W'(offset_bits_q);
    tag_d     = shift_sum[sac_pkg::SHIFT_W-1] ? '0 :
                sac_pkg::TAG_W'(address_i >> shift_sum[sac_pkg::SHIFT_W-2:0]);
    addr_sh   = address_i >> offset_bits_q;
    for (int i = 0; i < sac_pkg::SET_W; i++) begin
      set_mask[i] = (i < int'(set_bits_q));
    end
    set_d = addr_sh[sac_pkg::SET_W-1:0] & set_mask;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q <= tag_d;
      set_q <= set_d;
    end
  end

  // Set row storage: all ways of one set, tag and stamp per way.
  sac_pkg::line_t [NW-1:0] row_rd, row_wr;

  sac_ram #(
    .WIDTH (sac_pkg::ROW_W),
    .DEPTH (sac_pkg::MAX_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (set_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.capture),
    .raddr_i (set_d),
    .rdata_o (row_rd)
  );

  logic [NW-1:0] valid_q [sac_pkg::MAX_SETS];

  // Lookup and replacement decision on the row just read.
  logic [sac_pkg::WAYS_W-1:0]  ways_eff;
  logic [NW-1:0]               way_en, vrow, hit_vec, empty_vec;
  logic                        hit, have_empty, evict;
  logic [sac_pkg::WAY_W-1:0]   empty_way, lru_way, victim;
  logic [sac_pkg::STAMP_W-1:0] access_q, stamp_new;
  logic                        pick01, pick23, pick_hi;
  logic [sac_pkg::STAMP_W-1:0] lo_stamp, hi_stamp;

  always_comb begin
    if (ways_q == '0) begin
      ways_eff = sac_pkg::WAYS_W'(1);
    end else if (ways_q > sac_pkg::WAYS_W'(NW)) begin
      ways_eff = sac_pkg::WAYS_W'(NW);
    end else begin
      ways_eff = ways_q;
    end

    vrow       = valid_q[set_q];
    empty_way  = '0;
    for (int w = 0; w < NW; w++) begin
      way_en[w]    = (sac_pkg::WAYS_W'(w) < ways_eff);
      hit_vec[w]   = way_en[w] & vrow[w] & (row_rd[w].tag == tag_q);
      empty_vec[w] = way_en[w] & ~vrow[w];
      if (empty_vec[w]) begin
        empty_way = sac_pkg::WAY_W'(w);
      end
    end
    hit        = |hit_vec;
    have_empty = |empty_vec;
    evict      = ~hit & ~have_empty;

    // Two-level LRU tree; on equal stamps the higher way wins at every node.
    pick01   = way_en[1] && (row_rd[1].stamp <= row_rd[0].stamp);
    pick23   = way_en[3] && (row_rd[3].stamp <= row_rd[2].stamp);
    lo_stamp = pick01 ? row_rd[1].stamp : row_rd[0].stamp;
    hi_stamp = pick23 ? row_rd[3].stamp : row_rd[2].stamp;
    pick_hi  = way_en[2] && (hi_stamp <= lo_stamp);
    lru_way  = pick_hi ? (pick23 ? sac_pkg::WAY_W'(3) : sac_pkg::WAY_W'(2))
                       : (pick01 ? sac_pkg::WAY_W'(1) : sac_pkg::WAY_W'(0));

    victim    = have_empty ? empty_way : lru_way;
    stamp_new = (access_q == '1) ? access_q : access_q + sac_pkg::STAMP_W'(1);

    for (int w = 0; w < NW; w++) begin
      row_wr[w].tag   = (!hit && victim == sac_pkg::WAY_W'(w)) ? tag_q : row_rd[w].tag;
      row_wr[w].stamp = (hit_vec[w] || (!hit && victim == sac_pkg::WAY_W'(w))) ?
                        stamp_new : row_rd[w].stamp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sac_pkg::MAX_SETS; s++) begin
        valid_q[s] <= '0;
      end
      access_q         <= '0;
      hit_total_o      <= '0;
      miss_total_o     <= '0;
      eviction_total_o <= '0;
    end else if (cmd_i.commit) begin
      if (!hit) begin
        valid_q[set_q][victim] <= 1'b1;
      end
      access_q <= stamp_new;
      if (hit) begin
        hit_total_o <= sac_pkg::sat_inc(hit_total_o);
      end else begin
        miss_total_o <= sac_pkg::sat_inc(miss_total_o);
      end
      if (evict) begin
        eviction_total_o <= sac_pkg::sat_inc(eviction_total_o);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      was_hit_o      <= hit;
      was_miss_o     <= ~hit;
      was_eviction_o <= evict;
    end
  end

endmodule

### rtl/set_assoc_cache_lru_sim_top.sv
// Top level of the set-associative LRU cache simulator.
// Depends on sac_pkg, sac_ctrl, sac_dp (and through it sac_ram).
`timescale 1ns / 1ps
// Each request carries one byte address and yields one result with hit, miss and eviction
// flags plus saturating running totals. In the accept cycle the address is split and the
// set row is read from the row RAM; in the lookup state the tags are compared, the LRU
// victim is chosen and the updated row is written back once the result slot is free. A new
// request is taken in the cycle after the write-back and not before it, since the next
// request may touch the same set. While a finished result is stalled at the output, the
// next request is still accepted and read; it completes as soon as the result is taken.
// Valid bits are flip-flops cleared by reset, so the block is ready right after reset with
// no clearing pass. Configuration writes are always accepted and must only be issued while
// the block is idle.
module set_assoc_cache_lru_sim_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sac_pkg::ADDR_W-1:0]     address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           was_hit_o,
  output logic                           was_miss_o,
  output logic                           was_eviction_o,
  output logic [sac_pkg::CNT_W-1:0]      hit_total_o,
  output logic [sac_pkg::CNT_W-1:0]      miss_total_o,
  output logic [sac_pkg::CNT_W-1:0]      eviction_total_o
);

  sac_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  sac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  sac_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .address_i        (address_i),
    .was_hit_o        (was_hit_o),
    .was_miss_o       (was_miss_o),
    .was_eviction_o   (was_eviction_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .eviction_total_o (eviction_total_o)
  );

endmodule
